### rtl/lepm_pkg.sv
// Types and codes shared by the linked entry pool manager modules.
package lepm_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int HANDLE_W = 6;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_STEP    = 2'd2
  } func_e_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_EMPTY      = 2'd1,
    STS_NOT_IN_USE = 2'd2,
    STS_END        = 2'd3
  } status_e_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_HOLD
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]          func;
    logic [HANDLE_W-1:0] handle;
    logic                from_start;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] result_handle;
    logic [1:0]          status;
    logic                at_start;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic take;
    logic exec;
    logic link;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_link;
  } sts_t;

endpackage

### rtl/linked_entry_pool_manager.sv
// Top level of the linked entry pool manager.
// Allocate, step and the unused code load their result in state EXEC after acceptance, or from
// HOLD while the result is stalled; a successful release first passes LINK for its second link write.
// A new request is taken only in state IDLE, once the last one has put its result, because of the
// registered read of the link memories and their single write port; a stalled result holds the input.
// After reset a clearing pass over all NUM_ENTRIES entries builds the free chain, with req_stall high.
module linked_entry_pool_manager import lepm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp_data
);

  cmd_t cmd;
  sts_t sts;

  lepm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lepm_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req_data),
    .sts (sts),
    .rsp (rsp_data)
  );

endmodule

### rtl/lepm_ctrl.sv
// Controller state machine of the linked entry pool manager.
module lepm_ctrl import lepm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  fsm_state_t state, state_next;
  logic       rsp_valid_next;
  logic       rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_link) begin
          state_next = S_LINK;
        end else if (rsp_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_LINK: begin
        cmd.link = 1'b1;
        if (rsp_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (rsp_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rsp_valid_next = cmd.put || (rsp_valid && rsp_stall);
  end

endmodule

### rtl/lepm_dpath.sv
// Datapath of the linked entry pool manager: link memories, anchors and result register.
module lepm_dpath import lepm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output sts_t sts,
  output rsp_t rsp
);

  localparam int SW = $clog2(NUM_ENTRIES + 2);
  localparam int IW = $clog2(NUM_ENTRIES);
  localparam logic [SW-1:0] SLOT_ACT  = SW'(0);
  localparam logic [SW-1:0] SLOT_FREE = SW'(1);
  localparam logic [SW-1:0] SLOT_BASE = SW'(2);
  localparam logic [SW-1:0] SLOT_STEP = SW'(3);
  localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_ENTRIES - 1);

  logic [SW-1:0] nx_mem [NUM_ENTRIES];
  logic [SW-1:0] pv_mem [NUM_ENTRIES];
  logic          iu_mem [NUM_ENTRIES];

  logic [SW-1:0] head, tail, free_top;
  logic [SW-1:0] head_next, tail_next, free_top_next;
  logic [IW-1:0] clr_cnt;

  func_e_t       func_q;
  logic [HANDLE_W-1:0] hdl_q;
  logic          from_q, hok_q;
  logic [SW-1:0] nx_rd, pv_rd;
  logic          iu_rd;
  rsp_t          res_q, res_comb;

  logic          nx_we, pv_we, iu_we;
  logic [IW-1:0] nx_wa, pv_wa, iu_wa, raddr;
  logic [SW-1:0] nx_wd, pv_wd, step_n;
  logic          iu_wd;

  logic [IW-1:0] top_idx, tail_idx, hidx, p_idx, n_idx;
  logic [SW-1:0] hdl_slot;
  logic          empty, rel_ok;

  assign top_idx  = IW'(free_top - SLOT_BASE);
  assign tail_idx = IW'(tail - SLOT_BASE);
  assign hidx     = IW'(hdl_q);
  assign p_idx    = IW'(pv_rd - SLOT_BASE);
  assign n_idx    = IW'(nx_rd - SLOT_BASE);
  assign hdl_slot = SW'(hdl_q) + SLOT_BASE;
  assign empty    = (free_top == SLOT_FREE);
  assign rel_ok   = hok_q && iu_rd;
  assign raddr    = (req.func == FN_ALLOC) ? top_idx : IW'(req.handle);

  assign sts.clear_last = (clr_cnt == LAST_IDX);
  assign sts.need_link  = (func_q == FN_RELEASE) && rel_ok;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    free_top_next = free_top;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    iu_we = 1'b0; iu_wa = '0; iu_wd = 1'b0;
    res_comb = '0;
    step_n   = from_q ? head : nx_rd;

    if (cmd.clear) begin
      nx_we = 1'b1;
      nx_wa = clr_cnt;
      nx_wd = (clr_cnt == LAST_IDX) ? SLOT_FREE : SW'(clr_cnt) + SLOT_STEP;
      pv_we = 1'b1;
      pv_wa = clr_cnt;
      iu_we = 1'b1;
      iu_wa = clr_cnt;
    end

    if (cmd.take && (req.func == FN_ALLOC) && !empty && (tail != SLOT_ACT)) begin
      nx_we = 1'b1;
      nx_wa = tail_idx;
      nx_wd = free_top;
    end

    if (cmd.exec) begin
      case (func_q)
        FN_ALLOC: begin
          if (empty) begin
            res_comb.status = STS_EMPTY;
          end else begin
            free_top_next = nx_rd;
            tail_next     = free_top;
            if (tail == SLOT_ACT) begin
              head_next = free_top;
            end
            nx_we = 1'b1; nx_wa = top_idx; nx_wd = SLOT_ACT;
            pv_we = 1'b1; pv_wa = top_idx; pv_wd = tail;
            iu_we = 1'b1; iu_wa = top_idx; iu_wd = 1'b1;
            res_comb.result_handle = HANDLE_W'(free_top - SLOT_BASE);
          end
        end
        FN_RELEASE: begin
          if (!rel_ok) begin
            res_comb.status = STS_NOT_IN_USE;
          end else begin
            if (pv_rd == SLOT_ACT) begin
              head_next = nx_rd;
              res_comb.at_start = 1'b1;
            end else begin
              nx_we = 1'b1; nx_wa = p_idx; nx_wd = nx_rd;
              res_comb.result_handle = HANDLE_W'(pv_rd - SLOT_BASE);
            end
            if (nx_rd == SLOT_ACT) begin
              tail_next = pv_rd;
            end else begin
              pv_we = 1'b1; pv_wa = n_idx; pv_wd = pv_rd;
            end
            iu_we = 1'b1; iu_wa = hidx; iu_wd = 1'b0;
          end
        end
        FN_STEP: begin
          if (!from_q && !rel_ok) begin
            res_comb.status = STS_NOT_IN_USE;
          end else if (step_n == SLOT_ACT) begin
            res_comb.status = STS_END;
          end else begin
            res_comb.result_handle = HANDLE_W'(step_n - SLOT_BASE);
          end
        end
        default: begin
          res_comb = '0;
        end
      endcase
    end

    if (cmd.link) begin
      nx_we = 1'b1;
      nx_wa = hidx;
      nx_wd = free_top;
      free_top_next = hdl_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= SLOT_ACT;
      tail     <= SLOT_ACT;
      free_top <= SLOT_BASE;
      clr_cnt  <= '0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      free_top <= free_top_next;
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    if (cmd.take) begin
      nx_rd <= nx_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      pv_mem[pv_wa] <= pv_wd;
    end
    if (cmd.take) begin
      pv_rd <= pv_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (iu_we) begin
      iu_mem[iu_wa] <= iu_wd;
    end
    if (cmd.take) begin
      iu_rd <= iu_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_q <= func_e_t'(req.func);
      hdl_q  <= req.handle;
      from_q <= req.from_start;
      hok_q  <= (int'(req.handle) < NUM_ENTRIES);
    end
    if (cmd.exec) begin
      res_q <= res_comb;
    end
    if (cmd.put) begin
      rsp <= cmd.exec ? res_comb : res_q;
    end
  end

endmodule
